>>> rtl/rapp_pkg.sv
`default_nettype none

package rapp_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_LOG2     = $clog2(PAGE_BYTES);
  localparam int CELL_COUNT    = HISTORY_DEPTH - 1;
  localparam int UPS_W         = $clog2(HISTORY_DEPTH);
  localparam int UPS_LIMIT     = HISTORY_DEPTH * 3 / 4;

  localparam int OFF_W   = 48;
  localparam int LEN_W   = 32;
  localparam int CNT_W   = 32;
  localparam int RAO_W   = 49;
  localparam int RAS_W   = 24;
  localparam int DIMS_W  = 16;
  localparam int WIN_W   = 25;
  localparam int MAXV_W  = 25;
  localparam int CFG_W   = 25;
  localparam int BASE_W  = 23;

  localparam int RA_MAX_BYTES = 4 * 1024 * 1024;
  localparam int RA_MIN_BYTES = 64 * 1024;
  localparam int SEQ_LIMIT    = 4;
  localparam int RAND_LIMIT   = 8;
  // rate > 80 as floor(100h/t) >= 81, rate < 40 as 100h < 40t
  localparam int RATE_HI      = 81;
  localparam int RATE_LO      = 40;
  localparam int PCT_SCALE    = 100;

  localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(128);
  localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(1048576);
  localparam logic [MAXV_W-1:0] MAXV_RESET = MAXV_W'(2097152);

  typedef enum logic [1:0] {
    REG_VECTOR_DIMS     = 2'd0,
    REG_WINDOW_BYTES    = 2'd1,
    REG_ADAPTIVE_ENABLE = 2'd2,
    REG_MAX_VECTORS     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PAT_SEQUENTIAL = 2'd0,
    PAT_RANDOM     = 2'd1,
    PAT_CLUSTERED  = 2'd2
  } pattern_t;

  typedef enum logic {
    ACT_PREDICT = 1'b0,
    ACT_OBSERVE = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CLASS,
    S_BASE,
    S_ADAPT,
    S_CAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [0:0]       action;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } req_t;

  typedef struct packed {
    logic [RAO_W-1:0] ra_offset;
    logic [RAS_W-1:0] ra_size;
    logic [1:0]       pattern_class;
    logic [0:0]       window_hit;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/rapp_cell.sv
`default_nettype none

// One slot of the offset history line. Holds an older offset and flags
// whether its newer neighbor is strictly larger.
module rapp_cell
  import rapp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             shift,
  input  wire logic [OFF_W-1:0] newer,
  output logic      [OFF_W-1:0] offset,
  output logic                  up
);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      up     <= 1'b0;
    end else begin
      if (shift) begin
        offset <= newer;
      end
      up <= (newer > offset);
    end
  end

endmodule

`default_nettype wire

>>> rtl/readahead_pattern_predictor_core.sv
// The sequencer holds one item through history scan, classify, base size,
// adaptation, cap and done steps and accepts no new transaction until it
// returns to idle; the response is registered in the done step.
// A stalled response holds the sequencer in its last step until taken.
// Reset (rst, synchronous) clears history, counters and class and loads
// the configuration reset values.
`default_nettype none

module readahead_pattern_predictor_core
  import rapp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire req_t             req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rsp_t                  rsp
);

  logic [DIMS_W-1:0] vector_dims;
  logic [WIN_W-1:0]  window_bytes;
  logic              adaptive_enable;
  logic [MAXV_W-1:0] max_vectors;

  state_t state, state_next;

  logic [OFF_W-1:0] prev_offset;
  logic [LEN_W-1:0] prev_length;
  logic [CNT_W-1:0] seq_count, rand_count, hit_count, miss_count;
  pattern_t         current_class;

  logic             item_observe;
  logic             item_hit;
  logic [RAO_W-1:0] item_ra_offset;
  logic [CNT_W+7:0] hit_scaled, total_hi, total_lo;
  logic [BASE_W-1:0] base_sz;
  logic             adapt_up, adapt_down;
  logic [RAS_W-1:0] adapt_sz;
  logic [RAS_W-1:0] final_sz;

  logic [OFF_W-1:0] cell_off [CELL_COUNT];
  logic             cell_up  [CELL_COUNT];

  logic req_fire;
  assign req_stall = rst || (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_dims     <= DIMS_RESET;
      window_bytes    <= WIN_RESET;
      adaptive_enable <= 1'b0;
      max_vectors     <= MAXV_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VECTOR_DIMS:     vector_dims     <= cfg_data[DIMS_W-1:0];
        REG_WINDOW_BYTES:    window_bytes    <= cfg_data[WIN_W-1:0];
        REG_ADAPTIVE_ENABLE: adaptive_enable <= cfg_data[0];
        REG_MAX_VECTORS:     max_vectors     <= cfg_data[MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  // history line: prev_offset is the newest entry, cells hold the older ones
  for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
    rapp_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (req_fire),
      .newer  ((k == 0) ? prev_offset : cell_off[(k == 0) ? 0 : k-1]),
      .offset (cell_off[k]),
      .up     (cell_up[k])
    );
  end

  logic [UPS_W-1:0] ups;
  always_comb begin
    ups = '0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      ups = ups + UPS_W'(cell_up[i]);
    end
  end

  // window hit and sequential tests against the previous access
  logic [OFF_W:0]   expect_off;
  logic [OFF_W+1:0] window_end;
  logic             hit_now, seq_now;
  always_comb begin
    expect_off = {1'b0, prev_offset} + (OFF_W+1)'(prev_length);
    window_end = {1'b0, expect_off} + (OFF_W+2)'(window_bytes);
    hit_now    = ({1'b0, req.offset} >= expect_off) &&
                 ({2'b0, req.offset} < window_end);
    seq_now    = ({1'b0, req.offset} == expect_off);
  end

  // sizing arithmetic
  logic [CNT_W:0]    total;
  logic [WIN_W+1:0]  base_raw;
  logic [WIN_W+1:0]  base_rnd;
  logic [BASE_W-1:0] base_clamped;
  logic [WIN_W+1:0]  up_sz, win2, down_sz, adapt_res;
  logic [MAXV_W+1:0] cap_sz, cap_cls, cap_max;

  always_comb begin
    total = {1'b0, hit_count} + {1'b0, miss_count};

    case (current_class)
      PAT_SEQUENTIAL: base_raw = (WIN_W+2)'({vector_dims, 8'b0});
      PAT_RANDOM:     base_raw = (WIN_W+2)'({vector_dims, 5'b0});
      default:        base_raw = (WIN_W+2)'({vector_dims, 7'b0});
    endcase
    base_rnd = base_raw + (WIN_W+2)'(PAGE_BYTES - 1);
    base_rnd = {base_rnd[WIN_W+1:PAGE_LOG2], PAGE_LOG2'(0)};
    if (base_rnd < (WIN_W+2)'(RA_MIN_BYTES)) begin
      base_clamped = BASE_W'(RA_MIN_BYTES);
    end else if (base_rnd > (WIN_W+2)'(RA_MAX_BYTES)) begin
      base_clamped = BASE_W'(RA_MAX_BYTES);
    end else begin
      base_clamped = base_rnd[BASE_W-1:0];
    end

    win2    = (WIN_W+2)'({window_bytes, 1'b0});
    up_sz   = (WIN_W+2)'({base_sz, 1'b0});
    down_sz = (WIN_W+2)'(base_sz[BASE_W-1:1]);
    if (adapt_up) begin
      adapt_res = (up_sz > win2) ? win2 : up_sz;
    end else if (adapt_down) begin
      adapt_res = (down_sz < (WIN_W+2)'(RA_MIN_BYTES)) ?
                  (WIN_W+2)'(RA_MIN_BYTES) : down_sz;
    end else begin
      adapt_res = (WIN_W+2)'(base_sz);
    end

    cap_sz = (MAXV_W+2)'(adapt_sz);
    case (current_class)
      PAT_RANDOM:    cap_cls = (MAXV_W+2)'(window_bytes[WIN_W-1:2]);
      PAT_CLUSTERED: cap_cls = (MAXV_W+2)'(window_bytes[WIN_W-1:1]);
      default:       cap_cls = cap_sz;
    endcase
    if (cap_sz > cap_cls) begin
      cap_sz = cap_cls;
    end
    cap_max = {max_vectors, 2'b00};
    if (cap_sz > cap_max) begin
      cap_sz = cap_max;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_fire) state_next = S_SCAN;
      S_SCAN:  state_next = S_CLASS;
      S_CLASS: state_next = S_BASE;
      S_BASE:  state_next = S_ADAPT;
      S_ADAPT: state_next = S_CAP;
      S_CAP:   state_next = S_DONE;
      S_DONE:  if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_offset   <= '0;
      prev_length   <= '0;
      seq_count     <= '0;
      rand_count    <= '0;
      hit_count     <= '0;
      miss_count    <= '0;
      current_class <= PAT_SEQUENTIAL;
    end else begin
      if (req_fire) begin
        prev_offset <= req.offset;
        prev_length <= req.length;
        if (seq_now) begin
          seq_count <= seq_count + CNT_W'(seq_count != '1);
        end else begin
          rand_count <= rand_count + CNT_W'(rand_count != '1);
        end
        if (req.action == ACT_OBSERVE) begin
          if (hit_now) begin
            hit_count <= hit_count + CNT_W'(hit_count != '1);
          end else begin
            miss_count <= miss_count + CNT_W'(miss_count != '1);
          end
        end
      end
      if (state == S_CLASS) begin
        if (seq_count >= CNT_W'(SEQ_LIMIT) || ups >= UPS_W'(UPS_LIMIT)) begin
          current_class <= PAT_SEQUENTIAL;
        end else if (rand_count >= CNT_W'(RAND_LIMIT)) begin
          current_class <= PAT_RANDOM;
        end else begin
          current_class <= PAT_CLUSTERED;
        end
      end
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    if (req_fire) begin
      item_observe   <= (req.action == ACT_OBSERVE);
      item_hit       <= (req.action == ACT_OBSERVE) && hit_now;
      item_ra_offset <= RAO_W'(req.offset) + RAO_W'(req.length);
    end
    if (state == S_CLASS) begin
      hit_scaled <= (CNT_W+8)'(hit_count) * (CNT_W+8)'(PCT_SCALE);
      total_hi   <= (CNT_W+8)'(total) * (CNT_W+8)'(RATE_HI);
      total_lo   <= (CNT_W+8)'(total) * (CNT_W+8)'(RATE_LO);
    end
    if (state == S_BASE) begin
      base_sz    <= base_clamped;
      adapt_up   <= adaptive_enable && (total != '0) && (hit_scaled >= total_hi);
      adapt_down <= adaptive_enable && (total != '0) && (hit_scaled < total_lo);
    end
    if (state == S_ADAPT) begin
      adapt_sz <= adapt_res[RAS_W-1:0];
    end
    if (state == S_CAP) begin
      final_sz <= cap_sz[RAS_W-1:0];
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.ra_offset     <= item_observe ? '0 : item_ra_offset;
      rsp.ra_size       <= item_observe ? '0 : final_sz;
      rsp.pattern_class <= current_class;
      rsp.window_hit    <= item_hit;
    end
  end

`ifndef SYNTHESIS
  a_size_capped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((MAXV_W+2)'(rsp.ra_size) <= {max_vectors, 2'b00}))
    else $error("readahead size exceeds configured cap");

  a_hit_no_size: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.window_hit) |-> (rsp.ra_size == '0 && rsp.ra_offset == '0))
    else $error("observe response carries readahead data");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (hit_count >= $past(hit_count) && miss_count >= $past(miss_count)))
    else $error("hit or miss counter went backwards");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_valid && rsp_stall) |=> (rsp_valid && state == S_DONE))
    else $error("pending response dropped while stalled");
`endif

endmodule

`default_nettype wire
